/* hw/rtl/eecs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eecs_pkg: shared definitions for the encoder edge counter
// Widths, register map, sequencer states and divider status type.
// ----------------------------------------------------------------------------
package eecs_pkg;

    // Fixed field widths.
    localparam int SCALE_BITS   = 24;
    localparam int SPEED_BITS   = 25;
    localparam int POS_BITS     = 16;
    localparam int TIME_IN_BITS = 32;

    // Defaults for the top level parameters.
    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Register port.
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [PADDR_BITS-1:0] ADDR_SPEED_SCALE = 3'd0;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET      = 24'd1000000;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hw/rtl/eecs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eecs_sample_if / eecs_result_if: word channels of the encoder counter
// Valid/ready channels carrying one sample word and one result word.
// ----------------------------------------------------------------------------
interface eecs_sample_if;
    import eecs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    chan_a;
    logic                    chan_b;
    logic [TIME_IN_BITS-1:0] time_us;

    modport source (output valid, output chan_a, output chan_b, output time_us,
                    input ready);
    modport sink   (input valid, input chan_a, input chan_b, input time_us,
                    output ready);
endinterface

interface eecs_result_if;
    import eecs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [POS_BITS-1:0]   position_count;
    logic signed [SPEED_BITS-1:0] speed;
    logic                         edge_found;
    logic                         zero_interval;

    modport source (output valid, output position_count, output speed,
                    output edge_found, output zero_interval, input ready);
    modport sink   (input valid, input position_count, input speed,
                    input edge_found, input zero_interval, output ready);
endinterface

/* hw/rtl/eecs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eecs_div: iterative restoring divider
// One quotient bit per cycle; the quotient is valid while status.done is high.
// ----------------------------------------------------------------------------
module eecs_div #(
    parameter int DIVIDEND_BITS = eecs_pkg::SCALE_BITS,
    parameter int DIVISOR_BITS  = eecs_pkg::TIME_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output eecs_pkg::div_status_t    status
);
    import eecs_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [CNT_BITS-1:0]      cnt_reg,  cnt_next;
    logic                     done_reg, done_next;
    logic [DIVIDEND_BITS-1:0] q_reg,    q_next;
    logic [DIVISOR_BITS-1:0]  rem_reg,  rem_next;
    logic [DIVISOR_BITS-1:0]  dvs_reg,  dvs_next;

    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, q_reg[DIVIDEND_BITS-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_BITS'(DIVIDEND_BITS);
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_BITS'(1);
            done_next = (cnt_reg == CNT_BITS'(1));
            q_next    = {q_reg[DIVIDEND_BITS-2:0], fits};
            if (fits)
            begin
                rem_next = DIVISOR_BITS'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = q_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

/* hw/rtl/encoder_edge_count_speed.sv */
`timescale 1ns / 1ps
// Flow: a sample word without a rising edge on A goes from acceptance straight to the update
// step; an edge with a zero interval first passes the interval step, and any other edge passes
// the interval step, the divider steps and the quotient capture before the update.
// One word at a time: the next word is taken the cycle after the result is loaded, and the
// update step waits until the output register can take the result.
// Reset (rst_n, async, active low) clears all counter state and sets speed_scale to 1000000.
// ----------------------------------------------------------------------------
// encoder_edge_count_speed: x1 quadrature counter with period-based speed
// Counts rising edges of channel A with B as direction and divides the
// speed scale by the time between edges to get a signed speed.
// ----------------------------------------------------------------------------
module encoder_edge_count_speed #(
    parameter int TIME_BITS  = eecs_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = eecs_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    eecs_sample_if.sink                     sample_in,
    eecs_result_if.source                   result_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eecs_pkg::PADDR_BITS-1:0] paddr,
    input  logic [eecs_pkg::PDATA_BITS-1:0] pwdata,
    output logic [eecs_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready
);
    import eecs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register. The only register is the speed numerator;
    // it is written in the access phase of an APB write and read back
    // zero-extended. Any other address reads as zero and ignores writes.
    // ------------------------------------------------------------------
    logic [SCALE_BITS-1:0] scale_reg;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_SPEED_SCALE);
    assign prdata    = (paddr == ADDR_SPEED_SCALE) ?
                       PDATA_BITS'(scale_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            scale_reg <= pwdata[SCALE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sample timestamp cut or widened to the internal time width. The
    // interval arithmetic wraps at TIME_BITS bits.
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] time_in;

    generate
        if (TIME_BITS >= TIME_IN_BITS)
        begin : g_time_wide
            assign time_in = TIME_BITS'(sample_in.time_us);
        end
        else
        begin : g_time_narrow
            assign time_in = sample_in.time_us[TIME_BITS-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Sequencer state and the per-word working registers.
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;

    logic                  in_ready;
    logic                  div_start;
    logic                  load_result;
    logic                  accept;
    logic                  edge_now;
    logic                  out_free;

    // Architectural state of the counter.
    logic                  prev_a_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TIME_BITS-1:0]  last_time_reg;
    logic [SPEED_BITS-1:0] held_speed_reg;

    // Captured word and partial results.
    logic                  edge_reg;
    logic                  dir_up_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic [SCALE_BITS-1:0] mag_reg, mag_next;
    logic                  zero_reg, zero_next;

    // Interval since the previous edge, modulo 2^TIME_BITS.
    logic [TIME_BITS-1:0]  delta;
    logic                  delta_zero;

    // Shared divider.
    logic [SCALE_BITS-1:0] quotient;
    div_status_t           div_status;

    assign accept     = sample_in.valid && in_ready;
    assign edge_now   = sample_in.chan_a && !prev_a_reg;
    assign delta      = time_reg - last_time_reg;
    assign delta_zero = (delta == '0);

    eecs_div #(
        .DIVIDEND_BITS (SCALE_BITS),
        .DIVISOR_BITS  (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (delta),
        .quotient (quotient),
        .status   (div_status)
    );

    // Next state: a word with a rising edge walks through the interval step and,
    // unless the interval is zero, the divide steps; a word without one goes straight to the update step,
    // which waits there until the output register can take the result.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = edge_now ? ST_DELTA : ST_DONE;
                end
            end
            ST_DELTA:
            begin
                state_next = delta_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready    = 1'b1;
            ST_DELTA: div_start   = !delta_zero;
            ST_DIV:   load_result = 1'b0;
            ST_DONE:  load_result = out_free;
            default:  in_ready    = 1'b0;
        endcase
    end

    assign sample_in.ready = in_ready;

    // Speed magnitude: the scale itself for a zero interval, the quotient
    // otherwise. A scale of zero falls out as zero in both cases.
    always_comb
    begin
        mag_next  = mag_reg;
        zero_next = zero_reg;
        if (accept)
        begin
            mag_next  = '0;
            zero_next = 1'b0;
        end
        else if (state_reg == ST_DELTA && delta_zero)
        begin
            mag_next  = scale_reg;
            zero_next = 1'b1;
        end
        else if (state_reg == ST_DIV && div_status.done)
        begin
            mag_next = quotient;
        end
    end

    // ------------------------------------------------------------------
    // Counter update. B high counts up with a negative speed, B low
    // counts down with a positive speed. Without an edge the count and
    // speed repeat their held values.
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] count_new;
    logic [SPEED_BITS-1:0] speed_new;
    logic [SPEED_BITS-1:0] mag_wide;
    logic [POS_BITS-1:0]   pos_new;

    assign mag_wide = SPEED_BITS'(mag_reg);

    always_comb
    begin
        count_new = count_reg;
        speed_new = held_speed_reg;
        if (edge_reg)
        begin
            if (dir_up_reg)
            begin
                count_new = count_reg + COUNT_BITS'(1);
                speed_new = SPEED_BITS'(0) - mag_wide;
            end
            else
            begin
                count_new = count_reg - COUNT_BITS'(1);
                speed_new = mag_wide;
            end
        end
    end

    // The position output is the count sign-extended to 16 bits, or its
    // low 16 bits when the count is wider.
    generate
        if (COUNT_BITS >= POS_BITS)
        begin : g_pos_cut
            assign pos_new = count_new[POS_BITS-1:0];
        end
        else
        begin : g_pos_ext
            assign pos_new = {{(POS_BITS-COUNT_BITS){count_new[COUNT_BITS-1]}},
                              count_new};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register. It holds one finished result word; the sequencer
    // loads it when it is empty or being emptied in the same cycle.
    // ------------------------------------------------------------------
    logic                         out_valid_reg;
    logic signed [POS_BITS-1:0]   out_pos_reg;
    logic signed [SPEED_BITS-1:0] out_speed_reg;
    logic                         out_edge_reg;
    logic                         out_zero_reg;

    assign out_free = !out_valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            prev_a_reg     <= 1'b0;
            count_reg      <= '0;
            last_time_reg  <= '0;
            held_speed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                prev_a_reg <= sample_in.chan_a;
            end
            if (load_result)
            begin
                out_valid_reg  <= 1'b1;
                count_reg      <= count_new;
                held_speed_reg <= speed_new;
                if (edge_reg)
                begin
                    last_time_reg <= time_reg;
                end
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        zero_reg <= zero_next;
        if (accept)
        begin
            edge_reg   <= edge_now;
            dir_up_reg <= sample_in.chan_b;
            time_reg   <= time_in;
        end
        if (load_result)
        begin
            out_pos_reg   <= pos_new;
            out_speed_reg <= speed_new;
            out_edge_reg  <= edge_reg;
            out_zero_reg  <= zero_reg;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.position_count = out_pos_reg;
    assign result_out.speed          = out_speed_reg;
    assign result_out.edge_found     = out_edge_reg;
    assign result_out.zero_interval  = out_zero_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    // A saturated zero-interval result always comes from an edge word.
    a_zero_needs_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.zero_interval) |-> result_out.edge_found)
        else $error("zero interval flagged without an edge");

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample_in.ready)
        else $error("sample taken while the previous one is in work");

    // The divider is never restarted while it is still running.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");

endmodule
